// ===== hdl/cbq_pkg.sv =====
// Shared types and constants for the cascaded biquad filter.
package cbq_pkg;

    localparam int DEF_MAX_SECTIONS = 8;
    localparam int DEF_SAMPLE_WIDTH = 24;

    localparam int COEF_W    = 32;
    localparam int HIST_W    = 32;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 68;
    localparam int FRAC_BITS = 28;
    localparam int RND_W     = ACC_W - FRAC_BITS;
    localparam int CFG_ADDR_W = 3;

    localparam logic signed [COEF_W-1:0] ONE_Q = 32'sh1000_0000;
    localparam logic signed [ACC_W-1:0]  HALF_LSB = ACC_W'(68'sh800_0000);

    localparam logic [CFG_ADDR_W-1:0] REG_B0     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_B1     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_B2     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_A1     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_A2     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_STAGES = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ORDER  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN   = 3'd7;

    localparam logic [1:0] ORDER_FIRST  = 2'd1;
    localparam logic [1:0] ORDER_SECOND = 2'd2;

    typedef enum logic [2:0] {
        TERM_B0,
        TERM_B1,
        TERM_B2,
        TERM_A1,
        TERM_A2,
        TERM_GAIN
    } term_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_SEC,
        ST_GMUL,
        ST_GDRAIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic  load_x;
        logic  clr_acc;
        logic  mul_en;
        term_t term;
        logic  acc_en;
        logic  sec_write;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic       bypass;
        logic       first_order;
        logic [2:0] stage_count;
        logic       out_busy;
    } status_t;

endpackage

// ===== hdl/cascaded_biquad_iir_filter.sv =====
// Top level of the cascaded direct-form-I biquad filter with output gain.
// Each sample is captured, run through the sections in turn (none in bypass), then scaled
// by the gain. A new sample is accepted only after the previous one reaches the output register;
// the single shared 32x32 multiplier sets this, as it serves every section term and the gain.
// A result waiting in the output register holds the next result, not the next input.
// Reset (rst_n, async, active low): unity b0 and gain, other coefficients zero,
// one second-order section, history cleared. Writing stage_count clears history.
module cascaded_biquad_iir_filter
    import cbq_pkg::*;
#(
    parameter int MAX_SECTIONS = DEF_MAX_SECTIONS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [CFG_ADDR_W-1:0]                 cfg_addr,
    input  logic [COEF_W-1:0]                     cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // in_sample
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata   // out_sample
);

    localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int SEC_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    cmd_t             cmd;
    status_t          status;
    logic [SEC_W-1:0] sec;

    cbq_ctrl #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .SEC_W        (SEC_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd),
        .sec      (sec)
    );

    cbq_datapath #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SEC_W        (SEC_W),
        .DATA_W       (DATA_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .cmd       (cmd),
        .sec       (sec),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== hdl/cbq_ctrl.sv =====
// Sequencer for the shared multiply-accumulate over sections and output gain.
module cbq_ctrl
    import cbq_pkg::*;
#(
    parameter int MAX_SECTIONS = DEF_MAX_SECTIONS,
    parameter int SEC_W        = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  status_t          status,
    output cmd_t             cmd,
    output logic [SEC_W-1:0] sec
);

    localparam logic [SEC_W-1:0] LAST_MAX = SEC_W'(MAX_SECTIONS - 1);

    state_t           state_reg, state_next;
    term_t            term_reg, term_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic [SEC_W-1:0] last_sec;
    logic [4:0]       sc_ext;
    logic             accept;
    logic             last_term;

    assign sc_ext = {2'b00, status.stage_count};
    assign last_sec = (sc_ext >= 5'(MAX_SECTIONS - 1)) ? LAST_MAX : SEC_W'(status.stage_count);
    assign accept = in_valid && (state_reg == ST_IDLE);
    assign last_term = (term_reg == TERM_A2) || (status.first_order && (term_reg == TERM_A1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= TERM_B0;
            sec_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            sec_reg   <= sec_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        sec_next   = sec_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = status.bypass ? ST_GMUL : ST_MUL;
                    term_next  = TERM_B0;
                    sec_next   = '0;
                end
            end
            ST_MUL:
            begin
                if (last_term)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    unique case (term_reg)
                        TERM_B0: term_next = TERM_B1;
                        TERM_B1: term_next = status.first_order ? TERM_A1 : TERM_B2;
                        TERM_B2: term_next = TERM_A1;
                        TERM_A1: term_next = TERM_A2;
                        default: term_next = TERM_B0;
                    endcase
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SEC;
            end
            ST_SEC:
            begin
                term_next = TERM_B0;
                if (sec_reg == last_sec)
                begin
                    state_next = ST_GMUL;
                end
                else
                begin
                    state_next = ST_MUL;
                    sec_next   = sec_reg + 1'b1;
                end
            end
            ST_GMUL:
            begin
                state_next = ST_GDRAIN;
            end
            ST_GDRAIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.term      = term_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_x  = accept;
                cmd.clr_acc = accept;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.acc_en = (term_reg != TERM_B0);
            end
            ST_DRAIN:
            begin
                cmd.acc_en = 1'b1;
            end
            ST_SEC:
            begin
                cmd.sec_write = 1'b1;
                cmd.clr_acc   = 1'b1;
            end
            ST_GMUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.term   = TERM_GAIN;
            end
            ST_GDRAIN:
            begin
                cmd.acc_en = 1'b1;
            end
            ST_OUT:
            begin
                cmd.out_load = !status.out_busy;
            end
            default:
            begin
                cmd.term = term_reg;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign sec      = sec_reg;

endmodule

// ===== hdl/cbq_datapath.sv =====
// Coefficient registers, section history, shared multiplier, accumulator and output register.
module cbq_datapath
    import cbq_pkg::*;
#(
    parameter int MAX_SECTIONS = DEF_MAX_SECTIONS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int SEC_W        = 3,
    parameter int DATA_W       = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [COEF_W-1:0]       cfg_wdata,
    input  logic [SAMPLE_WIDTH-1:0] in_data,
    input  cmd_t                    cmd,
    input  logic [SEC_W-1:0]        sec,
    output status_t                 status,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [DATA_W-1:0]       out_data
);

    localparam logic signed [RND_W-1:0] HI32 = RND_W'(signed'(32'h7FFF_FFFF));
    localparam logic signed [RND_W-1:0] LO32 = RND_W'(signed'(32'h8000_0000));
    localparam logic signed [RND_W-1:0] HI_S =
        RND_W'($signed({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}));
    localparam logic signed [RND_W-1:0] LO_S =
        RND_W'($signed({1'b1, {(SAMPLE_WIDTH-1){1'b0}}}));

    logic signed [COEF_W-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg, gain_reg;
    logic [2:0]               stages_reg;
    logic [1:0]               order_reg;

    logic signed [HIST_W-1:0] hx1_reg [MAX_SECTIONS];
    logic signed [HIST_W-1:0] hx2_reg [MAX_SECTIONS];
    logic signed [HIST_W-1:0] hy1_reg [MAX_SECTIONS];
    logic signed [HIST_W-1:0] hy2_reg [MAX_SECTIONS];

    logic signed [HIST_W-1:0] x_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [HIST_W-1:0] op_a;
    logic signed [COEF_W-1:0] op_b;
    logic signed [ACC_W-1:0]  rnd_full;
    logic signed [RND_W-1:0]  rnd;
    logic signed [HIST_W-1:0] y_sec;
    logic [SAMPLE_WIDTH-1:0]  y_out;
    logic signed [SAMPLE_WIDTH-1:0] in_s;
    logic                     out_valid_reg;
    logic [SAMPLE_WIDTH-1:0]  out_data_reg;
    logic                     clear_hist;

    assign clear_hist = cfg_we && (cfg_addr == REG_STAGES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg     <= ONE_Q;
            b1_reg     <= '0;
            b2_reg     <= '0;
            a1_reg     <= '0;
            a2_reg     <= '0;
            gain_reg   <= ONE_Q;
            stages_reg <= '0;
            order_reg  <= ORDER_SECOND;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_B0:     b0_reg     <= cfg_wdata;
                REG_B1:     b1_reg     <= cfg_wdata;
                REG_B2:     b2_reg     <= cfg_wdata;
                REG_A1:     a1_reg     <= cfg_wdata;
                REG_A2:     a2_reg     <= cfg_wdata;
                REG_STAGES: stages_reg <= cfg_wdata[2:0];
                REG_ORDER:  order_reg  <= cfg_wdata[1:0];
                REG_GAIN:   gain_reg   <= cfg_wdata;
                default:    gain_reg   <= gain_reg;
            endcase
        end
    end

    assign status.bypass      = (order_reg != ORDER_FIRST) && (order_reg != ORDER_SECOND);
    assign status.first_order = (order_reg == ORDER_FIRST);
    assign status.stage_count = stages_reg;
    assign status.out_busy    = out_valid_reg && !out_ready;

    always_comb
    begin
        case (cmd.term)
            TERM_B0:   begin op_a = x_reg;        op_b = b0_reg;   end
            TERM_B1:   begin op_a = hx1_reg[sec]; op_b = b1_reg;   end
            TERM_B2:   begin op_a = hx2_reg[sec]; op_b = b2_reg;   end
            TERM_A1:   begin op_a = hy1_reg[sec]; op_b = a1_reg;   end
            TERM_A2:   begin op_a = hy2_reg[sec]; op_b = a2_reg;   end
            default:   begin op_a = x_reg;        op_b = gain_reg; end
        endcase
    end

    assign acc_next = acc_reg + ACC_W'(prod_reg);
    assign rnd_full = (acc_reg + HALF_LSB) >>> FRAC_BITS;
    assign rnd      = rnd_full[RND_W-1:0];
    assign y_sec    = (rnd > HI32) ? HIST_W'(HI32) :
                      (rnd < LO32) ? HIST_W'(LO32) : HIST_W'(rnd);
    assign y_out    = (rnd > HI_S) ? SAMPLE_WIDTH'(HI_S) :
                      (rnd < LO_S) ? SAMPLE_WIDTH'(LO_S) : SAMPLE_WIDTH'(rnd);
    assign in_s     = in_data;

    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
        begin
            x_reg <= HIST_W'(in_s);
        end
        else if (cmd.sec_write)
        begin
            x_reg <= y_sec;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= op_a * op_b;
        end
        if (cmd.clr_acc)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= y_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SECTIONS; i++)
            begin
                hx1_reg[i] <= '0;
                hx2_reg[i] <= '0;
                hy1_reg[i] <= '0;
                hy2_reg[i] <= '0;
            end
        end
        else if (clear_hist)
        begin
            for (int i = 0; i < MAX_SECTIONS; i++)
            begin
                hx1_reg[i] <= '0;
                hx2_reg[i] <= '0;
                hy1_reg[i] <= '0;
                hy2_reg[i] <= '0;
            end
        end
        else if (cmd.sec_write)
        begin
            hx1_reg[sec] <= x_reg;
            hy1_reg[sec] <= y_sec;
            if (!status.first_order)
            begin
                hx2_reg[sec] <= hx1_reg[sec];
                hy2_reg[sec] <= hy1_reg[sec];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = DATA_W'(out_data_reg);

endmodule

// ===== test/cascaded_biquad_iir_filter_checker.sv =====
// Checker for the cascaded biquad filter: tracks register writes, predicts and compares samples.
`timescale 1ns / 100ps

module cascaded_biquad_iir_filter_checker
    import cbq_pkg::*;
#(
    parameter int MAX_SEC = DEF_MAX_SECTIONS,
    parameter int DATA_W  = ((DEF_SAMPLE_WIDTH + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COEF_W-1:0]     cfg_wdata,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [DATA_W-1:0]     s_axis_tdata,   // in_sample
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [DATA_W-1:0]     m_axis_tdata,   // out_sample
    output int                    fail_count,
    output int                    pending,
    output int                    checked
);

    localparam logic signed [ACC_W-1:0] SEC_HI = 68'sd2147483647;
    localparam logic signed [ACC_W-1:0] SEC_LO = -68'sd2147483648;
    localparam logic signed [ACC_W-1:0] OUT_HI = 68'sd8388607;
    localparam logic signed [ACC_W-1:0] OUT_LO = -68'sd8388608;

    logic signed [COEF_W-1:0] b0, b1, b2, a1, a2, gain;
    logic [2:0]               stages;
    logic [1:0]               order;

    logic signed [HIST_W-1:0] past_in1  [MAX_SEC];
    logic signed [HIST_W-1:0] past_in2  [MAX_SEC];
    logic signed [HIST_W-1:0] past_out1 [MAX_SEC];
    logic signed [HIST_W-1:0] past_out2 [MAX_SEC];

    logic [DEF_SAMPLE_WIDTH-1:0] expected_out_q [$];

    function automatic void clear_history();
        for (int s = 0; s < MAX_SEC; s++)
        begin
            past_in1[s]  = '0;
            past_in2[s]  = '0;
            past_out1[s] = '0;
            past_out2[s] = '0;
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] round_clamp(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [ACC_W-1:0] hi,
        input logic signed [ACC_W-1:0] lo
    );
        logic signed [ACC_W-1:0] r;
        r = (acc + HALF_LSB) >>> FRAC_BITS;
        if (r > hi)
            return hi;
        if (r < lo)
            return lo;
        return r;
    endfunction

    function automatic logic [DEF_SAMPLE_WIDTH-1:0] filter_sample(
        input logic signed [DEF_SAMPLE_WIDTH-1:0] smp
    );
        logic signed [HIST_W-1:0] x;
        logic signed [HIST_W-1:0] y;
        logic signed [ACC_W-1:0]  acc;
        int                       n_sec;
        x = HIST_W'(smp);
        n_sec = int'(stages) + 1;
        if (n_sec > MAX_SEC)
            n_sec = MAX_SEC;
        if (order == ORDER_FIRST || order == ORDER_SECOND)
        begin
            for (int s = 0; s < n_sec; s++)
            begin
                if (order == ORDER_FIRST)
                    acc = x * b0 + past_in1[s] * b1 + past_out1[s] * a1;
                else
                    acc = x * b0 + past_in1[s] * b1 + past_in2[s] * b2
                        + past_out1[s] * a1 + past_out2[s] * a2;
                y = HIST_W'(round_clamp(acc, SEC_HI, SEC_LO));
                if (order == ORDER_SECOND)
                begin
                    past_in2[s]  = past_in1[s];
                    past_out2[s] = past_out1[s];
                end
                past_in1[s]  = x;
                past_out1[s] = y;
                x = y;
            end
        end
        acc = x * gain;
        acc = round_clamp(acc, OUT_HI, OUT_LO);
        return acc[DEF_SAMPLE_WIDTH-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0 = ONE_Q;
            b1 = '0;
            b2 = '0;
            a1 = '0;
            a2 = '0;
            gain = ONE_Q;
            stages = '0;
            order = ORDER_SECOND;
            clear_history();
            expected_out_q.delete();
            fail_count = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_B0:     b0 = cfg_wdata;
                    REG_B1:     b1 = cfg_wdata;
                    REG_B2:     b2 = cfg_wdata;
                    REG_A1:     a1 = cfg_wdata;
                    REG_A2:     a2 = cfg_wdata;
                    REG_STAGES:
                    begin
                        stages = cfg_wdata[2:0];
                        clear_history();
                    end
                    REG_ORDER:  order = cfg_wdata[1:0];
                    REG_GAIN:   gain = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_out_q.push_back(filter_sample(s_axis_tdata[DEF_SAMPLE_WIDTH-1:0]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_out_q.size() == 0)
                begin
                    $error("out_sample: unexpected transfer, got %0d",
                           $signed(m_axis_tdata[DEF_SAMPLE_WIDTH-1:0]));
                    fail_count++;
                end
                else
                begin
                    logic [DEF_SAMPLE_WIDTH-1:0] want;
                    want = expected_out_q.pop_front();
                    checked++;
                    if (m_axis_tdata[DEF_SAMPLE_WIDTH-1:0] !== want)
                    begin
                        $error("out_sample: expected %0d, got %0d", $signed(want),
                               $signed(m_axis_tdata[DEF_SAMPLE_WIDTH-1:0]));
                        fail_count++;
                    end
                end
            end
            pending = expected_out_q.size();
        end
    end

endmodule

// ===== test/cascaded_biquad_iir_filter_tb.sv =====
// Testbench top for the cascaded biquad filter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module cascaded_biquad_iir_filter_tb;
    import cbq_pkg::*;

    localparam int DATA_W        = ((DEF_SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_ITEMS  = 525;
    localparam int IDLE_LIMIT    = 20000;
    localparam int PRESSURE_HOLD = 1500;
    localparam int PRESSURE_PHASE = 3;

    localparam logic [1:0] ORDER_NONE  = 2'd0;
    localparam logic [1:0] ORDER_SPARE = 2'd3;

    localparam logic [DEF_SAMPLE_WIDTH-1:0] S_MAX = 24'h7FFFFF;
    localparam logic [DEF_SAMPLE_WIDTH-1:0] S_MIN = 24'h800000;
    localparam logic [DEF_SAMPLE_WIDTH-1:0] S_ONE = 24'h000001;
    localparam logic [DEF_SAMPLE_WIDTH-1:0] S_NEG = 24'hFFFFFF;

    localparam logic [COEF_W-1:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] C_MIN = 32'h8000_0000;
    localparam logic [COEF_W-1:0] C_HALF = 32'h0800_0000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [COEF_W-1:0]     cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata = '0;   // in_sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;        // out_sample

    int fail_count;
    int pending;
    int checked;

    int inputs_sent = 0;
    int hold_off_at = -1;
    int settings_done = 0;
    int idle_cycles = 0;
    bit tx_steady = 1'b0;

    logic [COEF_W-1:0]           cfg_val [8];
    logic [DEF_SAMPLE_WIDTH-1:0] sample_q [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cascaded_biquad_iir_filter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    cascaded_biquad_iir_filter_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked)
    );

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [COEF_W-1:0] rand_span(input int span);
        return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic apply_settings(input logic [7:0] mask);
        for (int i = 0; i < 8; i++)
        begin
            if (mask[i])
            begin
                cfg_we    <= 1'b1;
                cfg_addr  <= CFG_ADDR_W'(i);
                cfg_wdata <= cfg_val[i];
                @(negedge clk);
            end
        end
        cfg_we <= 1'b0;
        settings_done++;
    endtask

    task automatic push_sample(input logic [DEF_SAMPLE_WIDTH-1:0] smp);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'(smp);
        do
            @(posedge clk);
        while (!s_axis_tready);
        inputs_sent++;
        @(negedge clk);
    endtask

    // feed the queued samples, then wait for every result
    task automatic send_queue();
        while (sample_q.size() != 0)
            push_sample(sample_q.pop_front());
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin : rx_side
        int  stall;
        int  cyc;
        bit  pressed;
        bit  rx_steady;
        stall = 0;
        cyc = 0;
        pressed = 1'b0;
        rx_steady = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 256 == 0)
                rx_steady = ($urandom_range(0, 4) == 0);
            if (!pressed && hold_off_at >= 0 && inputs_sent >= hold_off_at)
            begin
                pressed = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (PRESSURE_HOLD) @(negedge clk);
            end
            if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_steady || $urandom_range(0, 99) < 60)
                m_axis_tready <= 1'b1;
            else
            begin
                stall = pick_gap(1'b0);
                m_axis_tready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d results outstanding", idle_cycles, pending);
            $display("[cascaded_biquad_iir_filter] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int         random_sent;
        int         phase;
        int         n_items;
        int         r;
        logic [7:0] mask;
        random_sent = 0;
        phase = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: unity pass-through
        sample_q = {S_MAX, S_MIN, 24'h000000, S_NEG, S_ONE, 24'h555555, 24'hAAAAAA};
        send_queue();

        // bypass with largest gain
        cfg_val[REG_ORDER] = COEF_W'(ORDER_NONE);
        cfg_val[REG_GAIN]  = C_MAX;
        mask = '0;
        mask[REG_ORDER] = 1'b1;
        mask[REG_GAIN]  = 1'b1;
        apply_settings(mask);
        sample_q = {S_MAX, S_MIN, S_ONE, S_NEG};
        send_queue();

        // other bypass code with most negative gain
        cfg_val[REG_ORDER] = COEF_W'(ORDER_SPARE);
        cfg_val[REG_GAIN]  = C_MIN;
        apply_settings(mask);
        sample_q = {S_MIN, S_MAX, 24'h000000};
        send_queue();

        // half gain: check rounding of halves
        cfg_val[REG_ORDER] = COEF_W'(ORDER_NONE);
        cfg_val[REG_GAIN]  = C_HALF;
        apply_settings(mask);
        sample_q = {S_ONE, S_NEG, 24'h000003};
        send_queue();

        // eight full sections, largest coefficients: drive history into saturation
        cfg_val[REG_B0] = C_MAX;
        cfg_val[REG_B1] = C_MAX;
        cfg_val[REG_B2] = C_MAX;
        cfg_val[REG_A1] = C_MAX;
        cfg_val[REG_A2] = C_MAX;
        cfg_val[REG_STAGES] = 32'd7;
        cfg_val[REG_ORDER]  = COEF_W'(ORDER_SECOND);
        cfg_val[REG_GAIN]   = ONE_Q;
        apply_settings(8'hFF);
        sample_q = {S_MAX, S_MAX, S_MIN, S_ONE};
        send_queue();

        // eight first-order sections, most negative coefficients
        cfg_val[REG_B0] = C_MIN;
        cfg_val[REG_B1] = C_MIN;
        cfg_val[REG_B2] = C_MIN;
        cfg_val[REG_A1] = C_MIN;
        cfg_val[REG_A2] = C_MIN;
        cfg_val[REG_ORDER] = COEF_W'(ORDER_FIRST);
        cfg_val[REG_GAIN]  = C_MAX;
        apply_settings(8'hFF);
        sample_q = {S_MAX, S_MIN, 24'h555555};
        send_queue();

        while (random_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                cfg_val[REG_B0] = rand_span(1 << 27);
                cfg_val[REG_B1] = rand_span(1 << 27);
                cfg_val[REG_B2] = rand_span(1 << 27);
                cfg_val[REG_A1] = rand_span(1 << 28);
                cfg_val[REG_A2] = rand_span(1 << 27);
                cfg_val[REG_GAIN] = ONE_Q + rand_span(1 << 26);
            end
            else
            begin
                cfg_val[REG_B0] = $urandom();
                cfg_val[REG_B1] = $urandom();
                cfg_val[REG_B2] = $urandom();
                cfg_val[REG_A1] = $urandom();
                cfg_val[REG_A2] = $urandom();
                cfg_val[REG_GAIN] = $urandom();
            end
            cfg_val[REG_STAGES] = $urandom_range(0, 7);
            r = $urandom_range(0, 19);
            if (r < 9)
                cfg_val[REG_ORDER] = COEF_W'(ORDER_SECOND);
            else if (r < 17)
                cfg_val[REG_ORDER] = COEF_W'(ORDER_FIRST);
            else if (r == 17)
                cfg_val[REG_ORDER] = COEF_W'(ORDER_NONE);
            else
                cfg_val[REG_ORDER] = COEF_W'(ORDER_SPARE);
            mask = 8'hFF;
            // keep history across some setting changes
            if ($urandom_range(0, 9) < 3)
                mask[REG_STAGES] = 1'b0;
            apply_settings(mask);

            tx_steady = ($urandom_range(0, 4) == 0);
            if (phase == PRESSURE_PHASE)
                hold_off_at = inputs_sent + 3;
            n_items = $urandom_range(25, 50);
            for (int i = 0; i < n_items; i++)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    sample_q.push_back(($urandom_range(0, 1) == 0) ? S_MAX : S_MIN);
                else if (r < 4)
                    sample_q.push_back(DEF_SAMPLE_WIDTH'(rand_span(4096)));
                else
                    sample_q.push_back(DEF_SAMPLE_WIDTH'($urandom()));
            end
            send_queue();
            random_sent += n_items;
            phase++;
        end

        repeat (80) @(negedge clk);
        $display("checked %0d filtered samples over %0d register settings", checked,
                 settings_done + 1);
        $display("orders 0 to 3, 1 to 8 sections, saturating extremes, one long output stall");
        if (fail_count == 0 && pending == 0)
            $display("[cascaded_biquad_iir_filter] OK");
        else
            $display("[cascaded_biquad_iir_filter] ERROR");
        $finish;
    end

endmodule
